### hw/rtl/dvrt_pkg.sv
// Shared types and constants of the distance-vector route table.
package dvrt_pkg;

   localparam int unsigned METRIC_WIDTH = 5;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_TICK   = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_ACTIVE  = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_MATCH_RD,
      FSM_MATCH_CHK,
      FSM_FREE_RD,
      FSM_FREE_CHK,
      FSM_TICK_RD,
      FSM_TICK_CHK,
      FSM_READ_RD,
      FSM_READ_CHK,
      FSM_DONE
   } fsm_type;

   localparam logic [1:0] CSR_MY_ADDRESS    = 2'd0;
   localparam logic [1:0] CSR_ROUTE_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_GARBAGE_DELAY = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic clear;      // free the entry at index
      logic load;       // capture request beat
      logic clr_index;  // index back to zero
      logic rd_status;  // read entry at index (result next cycle)
      logic rd_req;     // read entry named by entry_index
      logic inc_index;
      logic do_match;   // apply update rules to read entry
      logic do_install;
      logic do_tick;
      logic do_read;    // build advertisement
      logic set_full;
      logic out_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       own;       // destination is our own address
      logic       infinite;  // cost saturated
      logic       last;      // index at last entry
      logic       hit_match; // read entry is in use with same destination
      logic       hit_free;  // read entry is free
   } sts_type;

endpackage

### hw/rtl/dvrt_ctrl.sv
// Controller state machine that sequences the walks over the table.
module dvrt_ctrl
   import dvrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    out_busy,
   input  sts_type sts,
   output cmd_type cmd
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FSM_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (sts.last) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_DONE;
         end
         FSM_DONE: begin
            // first cycle after load: dispatch
            unique case (sts.op)
               OP_UPDATE: state_in = sts.own ? FSM_IDLE : FSM_MATCH_RD;
               OP_TICK:   state_in = FSM_TICK_RD;
               OP_READ:   state_in = FSM_READ_RD;
               default:   state_in = FSM_IDLE;
            endcase
            if (out_busy) state_in = FSM_DONE;
         end
         FSM_MATCH_RD:  state_in = FSM_MATCH_CHK;
         FSM_MATCH_CHK: begin
            if (sts.hit_match)     state_in = out_busy ? FSM_MATCH_CHK : FSM_IDLE;
            else if (!sts.last)    state_in = FSM_MATCH_RD;
            else if (sts.infinite) state_in = out_busy ? FSM_MATCH_CHK : FSM_IDLE;
            else                   state_in = FSM_FREE_RD;
         end
         FSM_FREE_RD:  state_in = FSM_FREE_CHK;
         FSM_FREE_CHK: begin
            if (sts.hit_free || sts.last) state_in = out_busy ? FSM_FREE_CHK : FSM_IDLE;
            else                          state_in = FSM_FREE_RD;
         end
         FSM_TICK_RD:  state_in = FSM_TICK_CHK;
         FSM_TICK_CHK: begin
            if (!sts.last)     state_in = FSM_TICK_RD;
            else if (!out_busy) state_in = FSM_IDLE;
         end
         FSM_READ_RD:  state_in = FSM_READ_CHK;
         FSM_READ_CHK: begin
            if (!out_busy) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         FSM_CLEAR: begin
            cmd.clear     = 1'b1;
            cmd.inc_index = !sts.last;
         end
         FSM_IDLE: begin
            req_stall     = 1'b0;
            cmd.load      = req_valid;
            cmd.clr_index = 1'b1;
         end
         FSM_DONE: begin
            if (!out_busy && ((sts.op == OP_UPDATE && sts.own) || sts.op == OP_NONE))
               cmd.out_load = 1'b1;
         end
         FSM_MATCH_RD, FSM_FREE_RD, FSM_TICK_RD: cmd.rd_status = 1'b1;
         FSM_READ_RD: cmd.rd_req = 1'b1;
         FSM_MATCH_CHK: begin
            if (sts.hit_match) begin
               cmd.do_match = !out_busy;
               cmd.out_load = !out_busy;
            end else if (!sts.last) begin
               cmd.inc_index = 1'b1;
            end else if (sts.infinite) begin
               cmd.out_load = !out_busy;
            end else begin
               cmd.clr_index = 1'b1;
            end
         end
         FSM_FREE_CHK: begin
            if (sts.hit_free) begin
               cmd.do_install = !out_busy;
               cmd.out_load   = !out_busy;
            end else if (sts.last) begin
               cmd.set_full = 1'b1;
               cmd.out_load = !out_busy;
            end else begin
               cmd.inc_index = 1'b1;
            end
         end
         FSM_TICK_CHK: begin
            if (!sts.last) begin
               cmd.do_tick   = 1'b1;
               cmd.inc_index = 1'b1;
            end else begin
               cmd.do_tick  = !out_busy;
               cmd.out_load = !out_busy;
            end
         end
         FSM_READ_CHK: begin
            cmd.do_read  = 1'b1;
            cmd.out_load = !out_busy;
         end
         default: ;
      endcase
   end

endmodule

### hw/rtl/dvrt_datapath.sv
// Datapath: table memories, update, aging and advertisement logic.
module dvrt_datapath
   import dvrt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES   = 128,
   parameter int unsigned METRIC_INFINITY = 16,
   parameter int unsigned INDEX_WIDTH     = 7
)(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [31:0]             my_address,
   input  logic [15:0]             route_timeout,
   input  logic [15:0]             garbage_delay,
   input  logic [1:0]              req_operation,
   input  logic [31:0]             req_now,
   input  logic [31:0]             req_gateway_address,
   input  logic [31:0]             req_dest_address,
   input  logic [7:0]              req_advertised_metric,
   input  logic [4:0]              req_link_cost,
   input  logic [INDEX_WIDTH-1:0]  req_entry_index,
   input  logic [31:0]             req_neighbor_address,
   output logic                    res_changed,
   output logic                    res_full,
   output logic                    res_valid,
   output logic [31:0]             res_destination,
   output logic [METRIC_WIDTH-1:0] res_metric
);

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam logic [METRIC_WIDTH-1:0] INF = METRIC_WIDTH'(METRIC_INFINITY);

   logic [1:0]              op_ff;
   logic [31:0]             now_ff, gw_ff, dst_ff, nb_ff;
   logic [METRIC_WIDTH-1:0] cost_ff;
   logic [INDEX_WIDTH-1:0]  ridx_ff;
   logic                    own_ff;
   logic [AW-1:0]           idx_ff;
   logic                    changed_ff, full_ff;

   logic [8:0] cost_sum;
   assign cost_sum = {1'b0, req_advertised_metric} + 9'(req_link_cost);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         now_ff  <= req_now;
         gw_ff   <= req_gateway_address;
         dst_ff  <= req_dest_address;
         nb_ff   <= req_neighbor_address;
         ridx_ff <= req_entry_index;
         own_ff  <= (req_dest_address == my_address);
         cost_ff <= (cost_sum > 9'(METRIC_INFINITY)) ? INF : METRIC_WIDTH'(cost_sum);
      end
   end

   // Status freed by a clearing pass after reset; payload in memories.
   status_type status_ff [TABLE_ENTRIES];
   logic [31:0]             dest_mem [TABLE_ENTRIES];
   logic [31:0]             gw_mem   [TABLE_ENTRIES];
   logic [METRIC_WIDTH-1:0] met_mem  [TABLE_ENTRIES];
   logic [31:0]             exp_mem  [TABLE_ENTRIES];
   logic [31:0]             free_mem [TABLE_ENTRIES];

   logic [AW-1:0] raddr;
   logic          ridx_ok;
   assign ridx_ok = (32'(ridx_ff) < 32'(TABLE_ENTRIES));
   assign raddr   = cmd.rd_req ? AW'(ridx_ff) : idx_ff;

   status_type              r_st;
   logic [31:0]             r_dst, r_gw, r_exp, r_free;
   logic [METRIC_WIDTH-1:0] r_met;
   logic                    r_ok;
   logic [AW-1:0]           waddr;

   always_ff @(posedge clock) begin
      if (cmd.rd_status || cmd.rd_req) begin
         r_st   <= status_ff[raddr];
         r_dst  <= dest_mem[raddr];
         r_gw   <= gw_mem[raddr];
         r_met  <= met_mem[raddr];
         r_exp  <= exp_mem[raddr];
         r_free <= free_mem[raddr];
         r_ok   <= cmd.rd_req ? ridx_ok : 1'b1;
         waddr  <= raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)               idx_ff <= '0;
      else if (cmd.clr_index)  idx_ff <= '0;
      else if (cmd.inc_index)  idx_ff <= idx_ff + AW'(1);
   end

   // Update, install and aging rules on the read entry.
   logic [31:0] exp_diff, now_plus_to, now_plus_gd, tk_exp, tk_free;
   logic        refresh_ok, gw_same;
   assign gw_same     = (r_gw == gw_ff);
   assign exp_diff    = r_exp - now_ff;
   assign now_plus_to = now_ff + 32'(route_timeout);
   assign now_plus_gd = now_ff + 32'(garbage_delay);
   assign refresh_ok  = exp_diff[31] || (exp_diff < 32'(route_timeout[15:1]));
   assign tk_exp      = now_ff - r_exp;
   assign tk_free     = now_ff - r_free;

   logic       wr_en, wr_all;
   status_type wr_st;
   logic [METRIC_WIDTH-1:0] wr_met;
   logic       wr_exp, wr_freed, chg;

   always_comb begin
      wr_en = 1'b0; wr_all = 1'b0; wr_st = r_st; wr_met = r_met;
      wr_exp = 1'b0; wr_freed = 1'b0; chg = 1'b0;
      if (cmd.do_match) begin
         if (cost_ff == INF) begin
            if (gw_same && r_met != INF) begin
               wr_en = 1'b1; wr_st = ST_TIMEOUT; wr_met = INF;
               wr_freed = 1'b1; chg = 1'b1;
            end
         end else if ((gw_same || r_met >= cost_ff) &&
                      (r_met > cost_ff || gw_same || refresh_ok)) begin
            wr_en = 1'b1; wr_st = ST_ACTIVE; wr_met = cost_ff; wr_exp = 1'b1;
            chg = (r_met != cost_ff) || !gw_same;
         end
      end else if (cmd.do_install) begin
         wr_en = 1'b1; wr_all = 1'b1; wr_st = ST_ACTIVE; wr_met = cost_ff;
         wr_exp = 1'b1; chg = 1'b1;
      end else if (cmd.do_tick) begin
         if (r_st == ST_ACTIVE && !tk_exp[31]) begin
            wr_en = 1'b1; wr_st = ST_TIMEOUT; wr_met = INF; wr_freed = 1'b1; chg = 1'b1;
         end else if (r_st == ST_TIMEOUT && !tk_free[31] && tk_free != '0) begin
            wr_en = 1'b1; wr_st = ST_FREE; chg = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         status_ff[idx_ff] <= ST_FREE;
      end else if (wr_en) begin
         status_ff[waddr] <= wr_st;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         met_mem[waddr] <= wr_met;
         if (wr_all || cmd.do_match) gw_mem[waddr] <= gw_ff;
         if (wr_all) dest_mem[waddr] <= dst_ff;
         if (wr_exp) exp_mem[waddr] <= now_plus_to;
         if (wr_freed) free_mem[waddr] <= now_plus_gd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         changed_ff <= 1'b0;
         full_ff    <= 1'b0;
      end else begin
         if (chg) changed_ff <= 1'b1;
         if (cmd.set_full) full_ff <= 1'b1;
      end
   end

   // Advertisement is built from the entry registered by the rd_req read.
   logic adv_hit;
   assign adv_hit = cmd.do_read && r_ok && (r_st != ST_FREE) && (r_dst != nb_ff);

   // Results are seen with this cycle's changes folded in.
   assign res_changed     = changed_ff | chg;
   assign res_full        = full_ff | cmd.set_full;
   assign res_valid       = adv_hit;
   assign res_destination = adv_hit ? r_dst : '0;
   assign res_metric      = adv_hit ? ((r_gw == nb_ff) ? INF : r_met) : '0;

   assign sts.op        = op_ff;
   assign sts.own       = own_ff;
   assign sts.infinite  = (cost_ff == INF);
   assign sts.last      = (idx_ff == AW'(TABLE_ENTRIES - 1));
   assign sts.hit_match = (r_st != ST_FREE) && (r_dst == dst_ff);
   assign sts.hit_free  = (r_st == ST_FREE);

endmodule

### hw/rtl/distance_vector_route_table.sv
// Top level of the distance-vector route table.
// Use: write my_address (0x0), route_timeout (0x4) and garbage_delay (0x8)
// over the csr_ port while idle. Send one operation per req_ beat: update,
// tick or read. Each beat gives exactly one rsp_ beat.
// An update walks the entries, reading and then checking each, looking
// for its destination; if none matches and its cost is finite, a second
// walk looks for a free entry. A tick walks every entry once. A read
// looks at the single entry named by req_entry_index; an update for our
// own address or an unused code walks no entries. All walks share the
// single table read port; one item is worked at a time. req_stall is
// high while an item is in work.
// The result sits in an output register; while rsp_stall holds it, the
// next item is accepted but waits before its walk starts.
// After reset a clearing pass frees one entry per cycle with req_stall
// high; the register defaults are restored at once.
module distance_vector_route_table
   import dvrt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES   = 128,
   parameter int unsigned METRIC_INFINITY = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_now,
   input  logic [31:0] req_gateway_address,
   input  logic [31:0] req_dest_address,
   input  logic [7:0]  req_advertised_metric,
   input  logic [4:0]  req_link_cost,
   input  logic [6:0]  req_entry_index,
   input  logic [31:0] req_neighbor_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_table_changed,
   output logic        rsp_table_full,
   output logic        rsp_entry_valid,
   output logic [31:0] rsp_entry_destination,
   output logic [4:0]  rsp_entry_metric
);

   logic [31:0] my_address_ff;
   logic [15:0] route_timeout_ff, garbage_delay_ff;
   logic        csr_wr;
   logic [1:0]  csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         my_address_ff    <= '0;
         route_timeout_ff <= 16'd180;
         garbage_delay_ff <= 16'd120;
      end else if (csr_wr && csr_paddr[1:0] == 2'b00) begin
         unique case (csr_reg)
            CSR_MY_ADDRESS:    my_address_ff    <= csr_pwdata;
            CSR_ROUTE_TIMEOUT: route_timeout_ff <= csr_pwdata[15:0];
            CSR_GARBAGE_DELAY: garbage_delay_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         CSR_MY_ADDRESS:    csr_prdata = my_address_ff;
         CSR_ROUTE_TIMEOUT: csr_prdata = {16'd0, route_timeout_ff};
         CSR_GARBAGE_DELAY: csr_prdata = {16'd0, garbage_delay_ff};
         default:           csr_prdata = '0;
      endcase
   end

   cmd_type cmd;
   sts_type sts;
   logic    out_busy;
   logic    res_changed, res_full, res_valid;
   logic [31:0] res_destination;
   logic [METRIC_WIDTH-1:0] res_metric;

   assign out_busy = rsp_valid && rsp_stall;

   dvrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_busy  (out_busy),
      .sts       (sts),
      .cmd       (cmd)
   );

   dvrt_datapath #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .METRIC_INFINITY (METRIC_INFINITY),
      .INDEX_WIDTH     (7)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .my_address            (my_address_ff),
      .route_timeout         (route_timeout_ff),
      .garbage_delay         (garbage_delay_ff),
      .req_operation         (req_operation),
      .req_now               (req_now),
      .req_gateway_address   (req_gateway_address),
      .req_dest_address      (req_dest_address),
      .req_advertised_metric (req_advertised_metric),
      .req_link_cost         (req_link_cost),
      .req_entry_index       (req_entry_index),
      .req_neighbor_address  (req_neighbor_address),
      .res_changed           (res_changed),
      .res_full              (res_full),
      .res_valid             (res_valid),
      .res_destination       (res_destination),
      .res_metric            (res_metric)
   );

   // Output register: load on the last step, drop on acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_table_changed     <= res_changed;
         rsp_table_full        <= res_full;
         rsp_entry_valid       <= res_valid;
         rsp_entry_destination <= res_destination;
         rsp_entry_metric      <= res_metric;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_busy) else $error("result overwritten while held");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("second item taken while busy");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_valid |-> !rsp_table_changed && !rsp_table_full)
      else $error("read result carries update flags");

endmodule

### test/distance_vector_route_table_tb.sv
// Self-checking testbench for the distance-vector route table.
`timescale 1ns / 1ps

module distance_vector_route_table_tb;
   import dvrt_pkg::*;

   localparam int ENTRIES   = 128;
   localparam int INFINITY  = 16;
   localparam int WDOG_MAX  = 20000;
   localparam int SETTLE    = 600;

   typedef struct {
      op_type      op;
      logic [31:0] now;
      logic [31:0] gw;
      logic [31:0] dest;
      logic [7:0]  adv;
      logic [4:0]  cost;
      logic [6:0]  idx;
      logic [31:0] nb;
   } route_req_type;

   typedef struct packed {
      logic        changed;
      logic        full;
      logic        valid;
      logic [31:0] dest;
      logic [4:0]  metric;
   } route_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_now = '0, req_gateway_address = '0, req_dest_address = '0;
   logic [7:0]  req_advertised_metric = '0;
   logic [4:0]  req_link_cost = '0;
   logic [6:0]  req_entry_index = '0;
   logic [31:0] req_neighbor_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_table_changed, rsp_table_full, rsp_entry_valid;
   logic [31:0] rsp_entry_destination;
   logic [4:0]  rsp_entry_metric;

   always #2 clock = ~clock;

   distance_vector_route_table dut (.*);

   // shadow of the table and registers
   status_type  tbl_status [ENTRIES];
   logic [31:0] tbl_dest   [ENTRIES];
   logic [31:0] tbl_gw     [ENTRIES];
   logic [4:0]  tbl_metric [ENTRIES];
   logic [31:0] tbl_expiry [ENTRIES];
   logic [31:0] tbl_free   [ENTRIES];
   logic [31:0] my_addr    = 32'd0;
   logic [15:0] timeout_reg = 16'd180;
   logic [15:0] garbage_reg = 16'd120;

   route_rsp_type expected_q [$];
   int          errors = 0;
   int          beats_in = 0, beats_out = 0, n_changed = 0, n_full = 0, n_valid = 0;
   int          stall_pct = 0;
   int          burst_left = 0;
   int          wdog = 0;
   logic [31:0] cur_now = 32'd1000;
   int          step_max = 20;
   int          dest_span = 48;

   function automatic route_rsp_type predict_route(route_req_type r);
      route_rsp_type res;
      logic [31:0]   cost, d;
      bit            found;
      res = '0;
      case (r.op)
         OP_UPDATE: begin
            cost = 32'(r.adv) + 32'(r.cost);
            if (cost > INFINITY) cost = INFINITY;
            if (r.dest != my_addr) begin
               found = 0;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (found || tbl_status[i] == ST_FREE || tbl_dest[i] != r.dest) continue;
                  found = 1;
                  if (cost == INFINITY) begin
                     if (r.gw == tbl_gw[i] && tbl_metric[i] != INFINITY) begin
                        tbl_status[i] = ST_TIMEOUT;
                        tbl_metric[i] = 5'(INFINITY);
                        tbl_free[i]   = r.now + 32'(garbage_reg);
                        res.changed   = 1'b1;
                     end
                  end else if (r.gw == tbl_gw[i] || tbl_metric[i] >= cost) begin
                     d = tbl_expiry[i] - r.now;
                     if (tbl_metric[i] > cost || tbl_gw[i] == r.gw || d[31] ||
                         d < 32'(timeout_reg >> 1)) begin
                        if (tbl_metric[i] != cost || tbl_gw[i] != r.gw) res.changed = 1'b1;
                        tbl_status[i] = ST_ACTIVE;
                        tbl_gw[i]     = r.gw;
                        tbl_metric[i] = cost[4:0];
                        tbl_expiry[i] = r.now + 32'(timeout_reg);
                     end
                  end
               end
               if (!found && cost != INFINITY) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (found || tbl_status[i] != ST_FREE) continue;
                     found = 1;
                     tbl_dest[i]   = r.dest;
                     tbl_gw[i]     = r.gw;
                     tbl_metric[i] = cost[4:0];
                     tbl_expiry[i] = r.now + 32'(timeout_reg);
                     tbl_status[i] = ST_ACTIVE;
                     res.changed   = 1'b1;
                  end
                  if (!found) res.full = 1'b1;
               end
            end
         end
         OP_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_status[i] == ST_ACTIVE) begin
                  d = r.now - tbl_expiry[i];
                  if (!d[31]) begin
                     tbl_status[i] = ST_TIMEOUT;
                     tbl_metric[i] = 5'(INFINITY);
                     tbl_free[i]   = r.now + 32'(garbage_reg);
                     res.changed   = 1'b1;
                  end
               end else if (tbl_status[i] == ST_TIMEOUT) begin
                  d = r.now - tbl_free[i];
                  if (!d[31] && d != 0) begin
                     tbl_status[i] = ST_FREE;
                     res.changed   = 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            if (tbl_status[r.idx] != ST_FREE && tbl_dest[r.idx] != r.nb) begin
               res.valid  = 1'b1;
               res.dest   = tbl_dest[r.idx];
               res.metric = (tbl_gw[r.idx] == r.nb) ? 5'(INFINITY) : tbl_metric[r.idx];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic route_req_type noise_req(op_type op);
      route_req_type r;
      r.op   = op;
      r.now  = $urandom;
      r.gw   = $urandom;
      r.dest = $urandom;
      r.adv  = 8'($urandom);
      r.cost = 5'($urandom_range(0, 16));
      r.idx  = 7'($urandom);
      r.nb   = $urandom;
      return r;
   endfunction

   function automatic route_req_type mk_update(logic [31:0] now, logic [31:0] gw,
                                               logic [31:0] dest, logic [7:0] adv,
                                               logic [4:0] cost);
      route_req_type r;
      r = noise_req(OP_UPDATE);
      r.now = now; r.gw = gw; r.dest = dest; r.adv = adv; r.cost = cost;
      return r;
   endfunction

   function automatic route_req_type mk_tick(logic [31:0] now);
      route_req_type r;
      r = noise_req(OP_TICK);
      r.now = now;
      return r;
   endfunction

   function automatic route_req_type mk_read(logic [6:0] idx, logic [31:0] nb);
      route_req_type r;
      r = noise_req(OP_READ);
      r.idx = idx; r.nb = nb;
      return r;
   endfunction

   function automatic logic [31:0] pick_gw();
      return ($urandom_range(9) == 0) ? $urandom : 32'hC0000001 + $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] pick_dest();
      int sel;
      sel = $urandom_range(19);
      if (sel == 0) return my_addr;
      if (sel == 1) return $urandom;
      return 32'h0A000000 + $urandom_range(1, dest_span);
   endfunction

   // Mostly well-formed traffic on a small address pool with advancing time.
   function automatic route_req_type gen_route_req();
      route_req_type r;
      int            sel;
      sel = $urandom_range(99);
      if (sel < 47) begin
         r = mk_update(cur_now, pick_gw(), pick_dest(),
                       ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                       ($urandom_range(7) == 0) ? 5'($urandom_range(0, 16))
                                                : 5'($urandom_range(1, 3)));
      end else if (sel < 70) begin
         r = mk_tick(cur_now);
      end else if (sel < 96) begin
         r = mk_read(($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, dest_span)),
                     ($urandom_range(3) == 0) ? pick_dest() : pick_gw());
      end else begin
         r = noise_req(($urandom_range(1) == 0) ? OP_NONE : OP_UPDATE);
      end
      cur_now = cur_now + $urandom_range(0, step_max);
      return r;
   endfunction

   // Called and returns at a falling edge; leaves valid high for a following beat.
   task automatic send_route_req(route_req_type r);
      req_valid             <= 1'b1;
      req_operation         <= r.op;
      req_now               <= r.now;
      req_gateway_address   <= r.gw;
      req_dest_address      <= r.dest;
      req_advertised_metric <= r.adv;
      req_link_cost         <= r.cost;
      req_entry_index       <= r.idx;
      req_neighbor_address  <= r.nb;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(predict_route(r));
      beats_in++;
      @(negedge clock);
   endtask

   task automatic idle_req(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_with_gaps(route_req_type r);
      if (burst_left == 0) begin
         idle_req($urandom_range(1, 12));
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_route_req(r);
   endtask

   task automatic drain_table();
      idle_req(1);
      while (expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_MY_ADDRESS:    my_addr     = value;
         CSR_ROUTE_TIMEOUT: timeout_reg = value[15:0];
         CSR_GARBAGE_DELAY: garbage_reg = value[15:0];
         default: ;
      endcase
   endtask

   task automatic run_random(int n);
      repeat (n) send_with_gaps(gen_route_req());
      drain_table();
   endtask

   // Install, advertise, refresh, replace, poison, own address, aging edges.
   task automatic test_directed();
      logic [31:0] t;
      t = 32'd1000;
      send_route_req(mk_update(t, 32'hC0000001, 32'h0A000001, 8'd1, 5'd1));
      send_route_req(mk_read(7'd0, 32'hC0000002));
      send_route_req(mk_read(7'd0, 32'hC0000001));
      send_route_req(mk_read(7'd0, 32'h0A000001));
      send_route_req(mk_update(t, 32'hC0000001, 32'h0A000001, 8'd4, 5'd1));
      send_route_req(mk_update(t, 32'hC0000002, 32'h0A000001, 8'd0, 5'd1));
      send_route_req(mk_update(t, 32'hC0000001, 32'h0A000001, 8'd3, 5'd1));
      send_route_req(mk_update(t + 10, 32'hC0000002, 32'h0A000001, 8'd255, 5'd16));
      send_route_req(mk_update(t, 32'hC0000003, 32'h0A000002, 8'd16, 5'd0));
      send_route_req(mk_update(t, 32'hC0000003, 32'h00000000, 8'd1, 5'd1));
      send_route_req(noise_req(OP_NONE));
      send_route_req(mk_update(t, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, 5'd15));
      send_route_req(mk_update(t, 32'h00000000, 32'h0A000003, 8'd0, 5'd0));
      send_route_req(mk_read(7'd1, 32'h00000000));
      send_route_req(mk_read(7'd127, 32'hFFFFFFFF));
      // freed only once now passes the garbage deadline, not on it
      send_route_req(mk_tick(t + 130));
      send_route_req(mk_tick(t + 131));
      send_route_req(mk_tick(t + 179));
      send_route_req(mk_tick(t + 180));
      send_route_req(mk_read(7'd1, 32'hC0000003));
      send_route_req(mk_tick(t + 301));
      drain_table();
   endtask

   // Fill every entry, overflow, then age the whole table out.
   task automatic test_table_full();
      logic [31:0] t;
      t = 32'd5000;
      for (int i = 0; i < ENTRIES + 3; i++)
         send_with_gaps(mk_update(t, pick_gw(), 32'hAC100000 + i, 8'($urandom_range(0, 14)),
                                  5'd1));
      send_with_gaps(mk_read(7'd127, 32'hC0000001));
      send_with_gaps(mk_tick(t + 180));
      send_with_gaps(mk_tick(t + 301));
      drain_table();
   endtask

   // Random traffic with default registers and a stalling receiver.
   task automatic test_stalled_traffic();
      stall_pct = 30;
      run_random(350);
   endtask

   task automatic test_fast_aging();
      write_csr(CSR_MY_ADDRESS, 32'hFFFFFFFF);
      write_csr(CSR_ROUTE_TIMEOUT, 32'd1);
      write_csr(CSR_GARBAGE_DELAY, 32'd1);
      stall_pct = 0; step_max = 2;
      run_random(250);
   endtask

   task automatic test_slow_aging_wrap();
      write_csr(CSR_MY_ADDRESS, 32'h0A000003);
      write_csr(CSR_ROUTE_TIMEOUT, 32'd65535);
      write_csr(CSR_GARBAGE_DELAY, 32'd65535);
      stall_pct = 60; step_max = 4000; cur_now = 32'hFFFF0000;
      run_random(300);
   endtask

   task automatic test_mixed_traffic();
      write_csr(CSR_MY_ADDRESS, 32'd0);
      write_csr(CSR_ROUTE_TIMEOUT, 32'd40);
      write_csr(CSR_GARBAGE_DELAY, 32'd25);
      stall_pct = 20; step_max = 12; dest_span = 140;
      run_random(500);
   endtask

   always @(negedge clock)
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      route_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (expected_q.size() == 0) begin
            $error("result beat with no expectation pending");
            errors++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp_table_changed !== exp_rsp.changed) begin
               $error("table_changed exp %0d got %0d", exp_rsp.changed, rsp_table_changed);
               errors++;
            end
            if (rsp_table_full !== exp_rsp.full) begin
               $error("table_full exp %0d got %0d", exp_rsp.full, rsp_table_full);
               errors++;
            end
            if (rsp_entry_valid !== exp_rsp.valid) begin
               $error("entry_valid exp %0d got %0d", exp_rsp.valid, rsp_entry_valid);
               errors++;
            end
            if (rsp_entry_destination !== exp_rsp.dest) begin
               $error("entry_destination exp %h got %h", exp_rsp.dest, rsp_entry_destination);
               errors++;
            end
            if (rsp_entry_metric !== exp_rsp.metric) begin
               $error("entry_metric exp %0d got %0d", exp_rsp.metric, rsp_entry_metric);
               errors++;
            end
            n_changed += exp_rsp.changed;
            n_full    += exp_rsp.full;
            n_valid   += exp_rsp.valid;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         wdog <= 0;
      end else if (wdog >= WDOG_MAX) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         wdog <= wdog + 1;
      end
   end

   initial begin
      foreach (tbl_status[i]) tbl_status[i] = ST_FREE;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_table_full();
      test_stalled_traffic();
      test_fast_aging();
      test_slow_aging_wrap();
      test_mixed_traffic();
      $display("Covered %0d operations / %0d results under four register settings:",
               beats_in, beats_out);
      $display("  %0d route changes, %0d table-full drops, %0d advertised entries",
               n_changed, n_full, n_valid);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
